// ===== rtl/circular_queue_with_search_defines.svh =====
// Assertion macros for the queue RTL.
`ifndef CIRCULAR_QUEUE_WITH_SEARCH_DEFINES_SVH
`define CIRCULAR_QUEUE_WITH_SEARCH_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define CQS_ASSERT_IMPLY(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("queue assertion failed");

// Next-cycle implication, checked out of reset.
`define CQS_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("queue assertion failed");

`endif

// ===== rtl/cqs_pkg.sv =====
// Types and constants shared by the circular queue with search.
package cqs_pkg;

    localparam int DEPTH      = 16;
    localparam int WORD_BITS  = 32;
    localparam int IDX_W      = $clog2(DEPTH);
    localparam int OCC_W      = $clog2(DEPTH + 1);
    localparam int CAP_W      = 5;
    localparam int POS_W      = 5;
    localparam int CMD_W      = 2;
    localparam int STATUS_W   = 2;
    localparam int IN_DATA_W  = ((WORD_BITS + 7) / 8) * 8;
    localparam int OUT_DATA_W = ((WORD_BITS + POS_W + 7) / 8) * 8;
    localparam int OUT_PAD_W  = OUT_DATA_W - WORD_BITS - POS_W;

    typedef enum logic [CMD_W-1:0] {
        CMD_ENQ    = 2'd0,
        CMD_DEQ    = 2'd1,
        CMD_SEARCH = 2'd2,
        CMD_NOP    = 2'd3
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK        = 2'd0,
        STAT_FULL      = 2'd1,
        STAT_EMPTY     = 2'd2,
        STAT_NOT_FOUND = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        OP_HOLD  = 2'd0,
        OP_LOAD  = 2'd1,
        OP_SHIFT = 2'd2
    } cell_op_t;

    typedef struct packed {
        cell_op_t op;
        logic     wrap;
    } cell_ctrl_t;

    typedef struct packed {
        status_t              status;
        logic [WORD_BITS-1:0] data;
        logic [POS_W-1:0]     position;
    } result_t;

endpackage

// ===== rtl/circular_queue_with_search.sv =====
// Top level of the circular queue with linear search over a chain of cells.
//
//  channel   dir  handshake                      content
//  s_axis    in   s_axis_tvalid/s_axis_tready    tuser: cmd, tdata: value
//  m_axis    out  m_axis_tvalid/m_axis_tready    tuser: status, tdata: data, position
//  cfg       in   cfg_valid/cfg_ready            cfg_data: capacity
//
// Enqueue, dequeue, no-op and refused requests pass through the result register and
// then the output register to m_axis; a search rotates the occupied cells once, one
// cell per cycle, and its result takes the same path. A new request is taken only in
// idle with the result register free. While m_axis stalls one more result waits in the
// result register. Reset is asynchronous and gives an empty queue of capacity 16; a
// capacity write also empties it and holds requests off while offered.
`include "circular_queue_with_search_defines.svh"

module circular_queue_with_search
    import cqs_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // [31:0] value
    input  logic [CMD_W-1:0]      s_axis_tuser,   // [1:0] cmd
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,   // [31:0] data, [36:32] position, rest zero
    output logic [STATUS_W-1:0]   m_axis_tuser,   // [1:0] status
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CAP_W-1:0]      cfg_data
);

    typedef enum logic [1:0] {
        S_IDLE   = 2'b01,
        S_SEARCH = 2'b10
    } state_t;

    state_t               state_reg, state_next;
    logic [OCC_W-1:0]     occ_reg, occ_next;
    logic [CAP_W-1:0]     cap_reg, cap_next;
    logic [OCC_W-1:0]     cnt_reg, cnt_next;
    logic                 found_reg, found_next;
    logic [POS_W-1:0]     pos_reg, pos_next;
    logic [WORD_BITS-1:0] key_reg, key_next;
    logic                 res_valid_reg, res_valid_next;
    result_t              res_reg, res_next;
    logic                 out_valid_reg, out_valid_next;
    result_t              out_reg, out_next;

    logic [WORD_BITS-1:0] cells [DEPTH];
    cell_ctrl_t           cell_ctrl [DEPTH];

    cmd_t                 cmd;
    logic [WORD_BITS-1:0] in_word;
    logic                 in_fire;
    logic                 cfg_fire;
    logic                 enq_ok;
    logic                 deq_ok;
    logic                 srch_start;
    logic                 searching;
    logic                 hit;
    logic [OCC_W-1:0]     last_idx;
    logic                 last_step;
    logic                 out_load;

    assign cmd        = cmd_t'(s_axis_tuser);
    assign in_word    = s_axis_tdata[WORD_BITS-1:0];
    assign searching  = (state_reg == S_SEARCH);
    assign cfg_ready  = (state_reg == S_IDLE);
    assign s_axis_tready = (state_reg == S_IDLE) && !res_valid_reg && !cfg_valid;
    assign in_fire    = s_axis_tvalid && s_axis_tready;
    assign cfg_fire   = cfg_valid && cfg_ready;
    assign enq_ok     = in_fire && (cmd == CMD_ENQ) && (occ_reg < cap_reg);
    assign deq_ok     = in_fire && (cmd == CMD_DEQ) && (occ_reg != '0);
    assign srch_start = in_fire && (cmd == CMD_SEARCH) && (occ_reg != '0);
    assign hit        = (cells[0] == key_reg);
    assign last_idx   = occ_reg - OCC_W'(1);
    assign last_step  = searching && (cnt_reg == last_idx);
    assign out_load   = res_valid_reg && (!out_valid_reg || m_axis_tready);

    // Cell 0 holds the head word outside a search; the chain shifts toward it.
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        always_comb
        begin
            cell_ctrl[i].op   = OP_HOLD;
            cell_ctrl[i].wrap = 1'b0;
            if (enq_ok && (occ_reg[IDX_W-1:0] == IDX_W'(i)))
            begin
                cell_ctrl[i].op = OP_LOAD;
            end
            else if (deq_ok)
            begin
                cell_ctrl[i].op = OP_SHIFT;
            end
            else if (searching && (OCC_W'(i) < occ_reg))
            begin
                cell_ctrl[i].op   = OP_SHIFT;
                cell_ctrl[i].wrap = (OCC_W'(i) == last_idx);
            end
        end

        cqs_cell u_cell (
            .clk       (clk),
            .ctrl      (cell_ctrl[i]),
            .next_word (cells[(i + 1) % DEPTH]),
            .head_word (cells[0]),
            .load_word (in_word),
            .word      (cells[i])
        );
    end

    always_comb
    begin
        state_next     = state_reg;
        occ_next       = occ_reg;
        cap_next       = cap_reg;
        cnt_next       = cnt_reg;
        found_next     = found_reg;
        pos_next       = pos_reg;
        key_next       = key_reg;
        res_next       = res_reg;
        res_valid_next = res_valid_reg && !out_load;

        unique case (state_reg)
            S_IDLE:
            begin
                if (cfg_fire)
                begin
                    if (cfg_data == '0)
                        cap_next = CAP_W'(1);
                    else if (cfg_data > CAP_W'(DEPTH))
                        cap_next = CAP_W'(DEPTH);
                    else
                        cap_next = cfg_data;
                    occ_next = '0;
                end
                else if (in_fire)
                begin
                    res_next.status   = STAT_OK;
                    res_next.data     = '0;
                    res_next.position = '0;
                    case (cmd)
                        CMD_ENQ:
                        begin
                            if (enq_ok)
                                occ_next = occ_reg + OCC_W'(1);
                            else
                                res_next.status = STAT_FULL;
                            res_valid_next = 1'b1;
                        end
                        CMD_DEQ:
                        begin
                            if (deq_ok)
                            begin
                                occ_next      = occ_reg - OCC_W'(1);
                                res_next.data = cells[0];
                            end
                            else
                            begin
                                res_next.status = STAT_EMPTY;
                            end
                            res_valid_next = 1'b1;
                        end
                        CMD_SEARCH:
                        begin
                            if (srch_start)
                            begin
                                state_next = S_SEARCH;
                                cnt_next   = '0;
                                found_next = 1'b0;
                                pos_next   = '0;
                                key_next   = in_word;
                            end
                            else
                            begin
                                res_next.status = STAT_EMPTY;
                                res_valid_next  = 1'b1;
                            end
                        end
                        default:
                        begin
                            res_valid_next = 1'b1;
                        end
                    endcase
                end
            end
            S_SEARCH:
            begin
                // The first hit wins; the rotation still runs full circle to restore order.
                if (!found_reg && hit)
                begin
                    found_next = 1'b1;
                    pos_next   = POS_W'(cnt_reg + OCC_W'(1));
                end
                cnt_next = cnt_reg + OCC_W'(1);
                if (last_step)
                begin
                    state_next        = S_IDLE;
                    res_next.status   = (found_reg || hit) ? STAT_OK : STAT_NOT_FOUND;
                    res_next.data     = '0;
                    res_next.position = found_reg ? pos_reg :
                                        (hit ? POS_W'(cnt_reg + OCC_W'(1)) : '0);
                    res_valid_next    = 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign out_valid_next = out_load || (out_valid_reg && !m_axis_tready);
    assign out_next       = out_load ? res_reg : out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            occ_reg       <= '0;
            cap_reg       <= CAP_W'(DEPTH);
            cnt_reg       <= '0;
            found_reg     <= 1'b0;
            res_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            occ_reg       <= occ_next;
            cap_reg       <= cap_next;
            cnt_reg       <= cnt_next;
            found_reg     <= found_next;
            res_valid_reg <= res_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg <= pos_next;
        key_reg <= key_next;
        res_reg <= res_next;
        out_reg <= out_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_reg.status;
    assign m_axis_tdata  = {{OUT_PAD_W{1'b0}}, out_reg.position, out_reg.data};

    `CQS_ASSERT_IMPLY(a_occ_within_cap, clk, rst_n, 1'b1, occ_reg <= cap_reg)
    `CQS_ASSERT_IMPLY(a_search_not_empty, clk, rst_n, searching, occ_reg != '0)
    `CQS_ASSERT_IMPLY(a_search_result_free, clk, rst_n, searching, !res_valid_reg)
    `CQS_ASSERT_NEXT(a_enq_grows, clk, rst_n, enq_ok, occ_reg == $past(occ_reg) + OCC_W'(1))

endmodule

// ===== rtl/cqs_cell.sv =====
// One storage cell of the queue chain: holds a word, loads or takes a neighbor's word.
module cqs_cell
    import cqs_pkg::*;
(
    input  logic                 clk,
    input  cell_ctrl_t           ctrl,
    input  logic [WORD_BITS-1:0] next_word,
    input  logic [WORD_BITS-1:0] head_word,
    input  logic [WORD_BITS-1:0] load_word,
    output logic [WORD_BITS-1:0] word
);

    logic [WORD_BITS-1:0] word_reg;
    logic [WORD_BITS-1:0] word_next;

    always_comb
    begin
        case (ctrl.op)
            OP_LOAD:  word_next = load_word;
            // The wrap flag closes the ring at the last occupied cell during a search.
            OP_SHIFT: word_next = ctrl.wrap ? head_word : next_word;
            default:  word_next = word_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign word = word_reg;

endmodule

// ===== tb/sv/tb.sv =====
// Self-checking testbench for the circular queue with linear search.
`timescale 1ns / 100ps

module tb;
    import cqs_pkg::*;

    localparam int QUIET_LIMIT = 500;
    localparam int TAIL_CYCLES = 24;
    localparam int PHASE_ITEMS = 95;

    // Predicts the result of every accepted request and holds the results still owed.
    class search_queue_model;
        logic [WORD_BITS-1:0] slots [DEPTH];
        int head;
        int tail;
        int count;
        int capacity;
        int mismatches;
        result_t expected_results [$];

        function new();
            capacity   = DEPTH;
            head       = 0;
            tail       = 0;
            count      = 0;
            mismatches = 0;
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

        function int step_index(int idx);
            return (idx + 1 >= capacity) ? 0 : idx + 1;
        endfunction

        // Word k places behind the head; only called for occupied slots.
        function logic [WORD_BITS-1:0] word_at(int k);
            int idx;
            idx = head + k;
            if (idx >= capacity)
                idx -= capacity;
            return slots[idx];
        endfunction

        // Out-of-range capacities are clamped, and any write empties the queue.
        function void set_capacity(logic [CAP_W-1:0] v);
            if (v == 0)
                capacity = 1;
            else if (v > DEPTH)
                capacity = DEPTH;
            else
                capacity = int'(v);
            head  = 0;
            tail  = 0;
            count = 0;
        endfunction

        function void predict_request(cmd_t op, logic [WORD_BITS-1:0] word);
            result_t r;
            int idx;
            r.status   = STAT_OK;
            r.data     = '0;
            r.position = '0;
            case (op)
                CMD_ENQ:
                begin
                    if (count >= capacity)
                        r.status = STAT_FULL;
                    else
                    begin
                        slots[tail] = word;
                        tail = step_index(tail);
                        count++;
                    end
                end
                CMD_DEQ:
                begin
                    if (count == 0)
                        r.status = STAT_EMPTY;
                    else
                    begin
                        r.data = slots[head];
                        head = step_index(head);
                        count--;
                    end
                end
                CMD_SEARCH:
                begin
                    if (count == 0)
                        r.status = STAT_EMPTY;
                    else
                    begin
                        r.status = STAT_NOT_FOUND;
                        idx = head;
                        for (int k = 0; k < count; k++)
                        begin
                            if (r.status == STAT_NOT_FOUND && slots[idx] == word)
                            begin
                                r.status   = STAT_OK;
                                r.position = POS_W'(k + 1);
                            end
                            idx = step_index(idx);
                        end
                    end
                end
                default:
                begin
                end
            endcase
            expected_results.push_back(r);
        endfunction

        function void note_mismatch(string msg);
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: mismatch: %s", $realtime, msg);
        endfunction

        function void compare_result(logic [STATUS_W-1:0] got_status,
                                     logic [WORD_BITS-1:0] got_data,
                                     logic [POS_W-1:0] got_pos);
            result_t want;
            if (expected_results.size() == 0)
            begin
                note_mismatch($sformatf("unexpected result status %0d data %h position %0d",
                                        got_status, got_data, got_pos));
                return;
            end
            want = expected_results.pop_front();
            if (got_status !== want.status || got_data !== want.data
                || got_pos !== want.position)
                note_mismatch($sformatf({"expected status %0d data %h position %0d, ",
                                         "got status %0d data %h position %0d"},
                                        want.status, want.data, want.position,
                                        got_status, got_data, got_pos));
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n         = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;   // [31:0] value
    logic [CMD_W-1:0]      s_axis_tuser  = '0;   // [1:0] cmd
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;         // [31:0] data, [36:32] position, rest zero
    logic [STATUS_W-1:0]   m_axis_tuser;         // [1:0] status
    logic                  cfg_valid     = 1'b0;
    logic                  cfg_ready;
    logic [CAP_W-1:0]      cfg_data      = '0;

    bit no_idle = 1'b0;
    search_queue_model model = new();

    circular_queue_with_search i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Valid stays high from one request to the next when no gap is drawn.
    task automatic send_request(cmd_t op, logic [WORD_BITS-1:0] word);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 4);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= word;
        do
            @(posedge clk);
        while (!s_axis_tready);
        model.predict_request(op, word);
    endtask

    // Always waits on a clock edge before it returns, so valid is never driven twice in one step.
    task automatic wait_for_results();
        s_axis_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (model.pending() != 0);
    endtask

    task automatic write_capacity(logic [CAP_W-1:0] v);
        wait_for_results();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        model.set_capacity(v);
    endtask

    // Small values make duplicate words common, so the first-match rule gets exercised.
    function automatic logic [WORD_BITS-1:0] pick_word();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000 + $urandom_range(0, 1);
            1: return 32'h7FFF_FFFE + $urandom_range(0, 1);
            2, 3: return $urandom_range(0, 7);
            default: return $urandom;
        endcase
    endfunction

    task automatic run_random_phase(int n_items);
        int roll;
        int enq_pct;
        cmd_t op;
        logic [WORD_BITS-1:0] word;
        for (int i = 0; i < n_items; i++)
        begin
            // Swing between filling and draining so both full and empty are reached.
            enq_pct = ((i / 32) % 2 == 0) ? 70 : 30;
            roll = $urandom_range(0, 99);
            if (roll < 3)
                op = CMD_NOP;
            else if (roll < 3 + enq_pct)
                op = CMD_ENQ;
            else if (roll % 2 == 0)
                op = CMD_DEQ;
            else
                op = CMD_SEARCH;
            word = pick_word();
            if (op == CMD_SEARCH && model.count > 0 && $urandom_range(0, 3) != 0)
                word = model.word_at($urandom_range(0, model.count - 1));
            if ($urandom_range(0, 149) == 0)
                wait_for_results();
            send_request(op, word);
        end
    endtask

    initial
    begin
        logic [CAP_W-1:0] caps [10];
        caps = '{5'd0, 5'd1, 5'd16, 5'd17, 5'd31, 5'd2, 5'd3, 5'd0, 5'd0, 5'd16};
        caps[7] = CAP_W'($urandom_range(1, 31));
        caps[8] = CAP_W'($urandom_range(1, 31));

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty queue at reset capacity, then signed extremes and searches.
        send_request(CMD_DEQ, 32'h0);
        send_request(CMD_SEARCH, 32'h0);
        send_request(CMD_NOP, 32'hFFFF_FFFF);
        send_request(CMD_ENQ, 32'h7FFF_FFFF);
        send_request(CMD_ENQ, 32'h8000_0000);
        send_request(CMD_ENQ, 32'hFFFF_FFFF);
        send_request(CMD_ENQ, 32'h0);
        send_request(CMD_SEARCH, 32'hFFFF_FFFF);
        send_request(CMD_SEARCH, 32'h1234_5678);
        send_request(CMD_SEARCH, 32'h7FFF_FFFF);
        send_request(CMD_SEARCH, 32'h0);
        send_request(CMD_DEQ, 32'hFFFF_FFFF);
        send_request(CMD_NOP, 32'h5555_AAAA);

        // Shrinking the capacity empties the queue; then full, wrap and empty again.
        write_capacity(5'd2);
        send_request(CMD_SEARCH, 32'h8000_0000);
        send_request(CMD_ENQ, 32'hA5A5_A5A5);
        send_request(CMD_ENQ, 32'h5A5A_5A5A);
        send_request(CMD_ENQ, 32'h1);
        send_request(CMD_DEQ, 32'h0);
        send_request(CMD_ENQ, 32'hA5A5_A5A5);
        send_request(CMD_SEARCH, 32'hA5A5_A5A5);
        send_request(CMD_DEQ, 32'h0);
        send_request(CMD_DEQ, 32'h0);
        send_request(CMD_DEQ, 32'h0);

        for (int phase = 0; phase < 10; phase++)
        begin
            write_capacity(caps[phase]);
            no_idle = (phase % 4 == 3);
            run_random_phase(PHASE_ITEMS);
        end
        no_idle = 1'b0;

        wait_for_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (model.mismatches == 0 && model.pending() == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

    initial
    begin
        int stall;
        @(posedge rst_n);
        forever
        begin
            stall = no_idle ? 0 : $urandom_range(0, 4);
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_axis_tvalid);
            model.compare_result(m_axis_tuser, m_axis_tdata[WORD_BITS-1:0],
                                 m_axis_tdata[WORD_BITS +: POS_W]);
        end
    end

    // Ends the run when no request, result or register write moves for too long.
    initial
    begin
        int quiet;
        quiet = 0;
        @(posedge rst_n);
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("tb failed");
        $finish;
    end

endmodule
